// ----- rtl/cweb_pkg.sv -----
`timescale 1ns / 1ps

package cweb_pkg;

    localparam int TIME_BITS   = 48;
    localparam int TOF_BITS    = TIME_BITS + 1;
    localparam int WINDOW_BITS = 32;
    localparam int TYPE_BITS   = 3;
    localparam int FLAG_BITS   = 3;
    localparam int CMP_BITS    = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(1000);

    // both start and stop seen
    localparam logic [FLAG_BITS-1:0] PAIR_MASK = FLAG_BITS'(3);

    typedef enum logic {
        CMD_HIT   = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef enum logic [TYPE_BITS-1:0] {
        TYPE_START = 3'd0,
        TYPE_STOP  = 3'd1,
        TYPE_AUX   = 3'd2
    } hit_type_t;

    typedef struct packed {
        logic                  cmd;
        logic                  hit_valid;
        logic [TYPE_BITS-1:0]  hit_type;
        logic [TIME_BITS-1:0]  hit_time;
    } hit_item_t;

    // input register to group stage
    typedef struct packed {
        logic      valid;
        hit_item_t item;
    } stage_item_t;

endpackage

// ----- rtl/cweb_in_stage.sv -----
`timescale 1ns / 1ps

module cweb_in_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic                                hit_valid,
    input  logic [cweb_pkg::TYPE_BITS-1:0]      hit_type,
    input  logic [cweb_pkg::TIME_BITS-1:0]      hit_time,
    output cweb_pkg::stage_item_t               stage,
    input  logic                                take
);
    import cweb_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    hit_item_t item_reg;

    // hold while the group stage cannot take the item
    assign in_stall = valid_reg && !take;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.cmd       <= cmd;
            item_reg.hit_valid <= hit_valid;
            item_reg.hit_type  <= hit_type;
            item_reg.hit_time  <= hit_time;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ----- rtl/cweb_group.sv -----
`timescale 1ns / 1ps

module cweb_group (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cweb_pkg::WINDOW_BITS-1:0]    cfg_wdata,
    input  cweb_pkg::stage_item_t               stage,
    output logic                                take,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cweb_pkg::FLAG_BITS-1:0]      event_flags,
    output logic                                event_valid,
    output logic signed [cweb_pkg::TOF_BITS-1:0] event_tof
);
    import cweb_pkg::*;

    logic [WINDOW_BITS-1:0] window_reg;
    logic [FLAG_BITS-1:0]   flags_reg,  flags_next;
    logic                   valid_reg,  valid_next;
    logic [TOF_BITS-1:0]    tof_reg,    tof_next;
    logic [TIME_BITS-1:0]   ref_reg,    ref_next;

    logic                   out_valid_reg, out_valid_next;
    logic [FLAG_BITS-1:0]   out_flags_reg;
    logic                   out_evalid_reg;
    logic [TOF_BITS-1:0]    out_tof_reg;

    logic                   out_free;
    logic                   group_empty;
    logic                   is_hit;
    logic                   ref_ge;
    logic [TIME_BITS-1:0]   diff_fwd, diff_bwd, diff;
    logic                   in_window;
    logic                   start_new;
    logic                   emit;
    logic [FLAG_BITS-1:0]   base_flags;
    logic                   base_valid;
    logic [TOF_BITS-1:0]    base_tof;
    logic [FLAG_BITS-1:0]   type_bit;
    logic                   type_known;
    logic [TOF_BITS-1:0]    t_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign take     = out_free;

    assign group_empty = (flags_reg == '0);
    assign is_hit      = (stage.item.cmd == CMD_HIT) && stage.item.hit_valid;

    // magnitude of the time difference, both orders formed in parallel
    assign ref_ge    = (stage.item.hit_time >= ref_reg);
    assign diff_fwd  = stage.item.hit_time - ref_reg;
    assign diff_bwd  = ref_reg - stage.item.hit_time;
    assign diff      = ref_ge ? diff_fwd : diff_bwd;
    assign in_window = (CMP_BITS'(diff) < CMP_BITS'(window_reg));

    assign start_new = group_empty || !in_window;
    assign t_ext     = TOF_BITS'(stage.item.hit_time);

    assign type_known = (stage.item.hit_type == TYPE_START) ||
                        (stage.item.hit_type == TYPE_STOP)  ||
                        (stage.item.hit_type == TYPE_AUX);
    assign type_bit   = type_known ? (FLAG_BITS'(1) << stage.item.hit_type) : '0;

    always_comb
    begin
        flags_next     = flags_reg;
        valid_next     = valid_reg;
        tof_next       = tof_reg;
        ref_next       = ref_reg;
        emit           = 1'b0;
        base_flags     = flags_reg;
        base_valid     = valid_reg;
        base_tof       = tof_reg;

        if (stage.valid && out_free)
        begin
            if (stage.item.cmd == CMD_FLUSH)
            begin
                emit       = !group_empty;
                flags_next = '0;
                valid_next = 1'b0;
                tof_next   = '0;
            end
            else if (is_hit)
            begin
                emit = !group_empty && !in_window;
                if (start_new)
                begin
                    base_flags = '0;
                    base_valid = 1'b0;
                    base_tof   = '0;
                    ref_next   = stage.item.hit_time;
                end
                flags_next = base_flags;
                valid_next = base_valid;
                tof_next   = base_tof;
                // only the first hit of each type counts
                if ((base_flags & type_bit) == '0)
                begin
                    flags_next = base_flags | type_bit;
                    if (stage.item.hit_type == TYPE_START)
                    begin
                        tof_next = base_tof - t_ext;
                    end
                    else if (stage.item.hit_type == TYPE_STOP)
                    begin
                        tof_next = base_tof + t_ext;
                    end
                    if (((base_flags | type_bit) & PAIR_MASK) == PAIR_MASK)
                    begin
                        valid_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            flags_reg     <= '0;
            valid_reg     <= 1'b0;
            tof_reg       <= '0;
            ref_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            flags_reg     <= flags_next;
            valid_reg     <= valid_next;
            tof_reg       <= tof_next;
            ref_reg       <= ref_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the emitted group is the state before this item
    always_ff @(posedge clk)
    begin
        if (out_free && emit)
        begin
            out_flags_reg  <= flags_reg;
            out_evalid_reg <= valid_reg;
            out_tof_reg    <= tof_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_flags = out_flags_reg;
    assign event_valid = out_evalid_reg;
    assign event_tof   = $signed(out_tof_reg);

endmodule

// ----- rtl/coincidence_window_event_builder_unit.sv -----
`timescale 1ns / 1ps
// An event leaves through the result register: the item that closes it passes the input
// register, then the group update writes the event into the result register.
// Throughput: one item per cycle unless a full result register is stalled, set by the
// combinational group update (subtract, window compare, flag merge) in between.
// Reset (rst_n low, asynchronous): group and reference time cleared, window set to 1000.

module coincidence_window_event_builder_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cweb_pkg::WINDOW_BITS-1:0]     cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic                                 hit_valid,
    input  logic [cweb_pkg::TYPE_BITS-1:0]       hit_type,
    input  logic [cweb_pkg::TIME_BITS-1:0]       hit_time,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [cweb_pkg::FLAG_BITS-1:0]       event_flags,
    output logic                                 event_valid,
    output logic signed [cweb_pkg::TOF_BITS-1:0] event_tof
);
    import cweb_pkg::*;

    stage_item_t stage;
    logic        take;

    cweb_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .hit_valid (hit_valid),
        .hit_type  (hit_type),
        .hit_time  (hit_time),
        .stage     (stage),
        .take      (take)
    );

    cweb_group u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .stage       (stage),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_flags (event_flags),
        .event_valid (event_valid),
        .event_tof   (event_tof)
    );

endmodule

// ----- verif/cweb_tb_pkg.sv -----
`timescale 1ns / 1ps

package cweb_tb_pkg;

    import cweb_pkg::*;

    typedef struct packed {
        logic [FLAG_BITS-1:0] flags;
        logic                 valid;
        logic [TOF_BITS-1:0]  tof;
    } event_rec_t;

    class coincidence_tracker;
        logic [WINDOW_BITS-1:0] window;
        logic [FLAG_BITS-1:0]   flags;
        logic                   pair_seen;
        logic [TOF_BITS-1:0]    tof;
        logic [TIME_BITS-1:0]   anchor_time;
        event_rec_t             due_events[$];
        int                     mismatches;
        int                     checked;

        function new();
            window      = WINDOW_RESET;
            flags       = '0;
            pair_seen   = 1'b0;
            tof         = '0;
            anchor_time = '0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void set_window(logic [WINDOW_BITS-1:0] w);
            window = w;
        endfunction

        function void merge_hit(logic [TYPE_BITS-1:0] ty, logic [TIME_BITS-1:0] t);
            logic [FLAG_BITS-1:0] bit_mask;
            if (ty > TYPE_AUX)
                return;
            bit_mask = FLAG_BITS'(1) << ty;
            if ((flags & bit_mask) != '0)
                return;
            flags = flags | bit_mask;
            if (ty == TYPE_START)
                tof = tof - {1'b0, t};
            else if (ty == TYPE_STOP)
                tof = tof + {1'b0, t};
            if ((flags & PAIR_MASK) == PAIR_MASK)
                pair_seen = 1'b1;
        endfunction

        // emit the open group and clear it; reference time is left alone
        function void close_group();
            event_rec_t ev;
            ev.flags  = flags;
            ev.valid  = pair_seen;
            ev.tof    = tof;
            due_events.push_back(ev);
            flags     = '0;
            pair_seen = 1'b0;
            tof       = '0;
        endfunction

        function void accept_item(logic c, logic hv, logic [TYPE_BITS-1:0] ty,
                                  logic [TIME_BITS-1:0] t);
            logic [TIME_BITS-1:0] diff;
            if (c == CMD_FLUSH)
            begin
                if (flags != '0)
                    close_group();
                return;
            end
            if (!hv)
                return;
            if (flags == '0)
            begin
                merge_hit(ty, t);
                anchor_time = t;
                return;
            end
            diff = (t >= anchor_time) ? t - anchor_time : anchor_time - t;
            if (diff < TIME_BITS'(window))
            begin
                merge_hit(ty, t);
                return;
            end
            close_group();
            merge_hit(ty, t);
            anchor_time = t;
        endfunction

        task report(string msg);
            if (mismatches < 200)
                $display("%0t ERROR: %s", $time, msg);
            mismatches++;
        endtask

        task check_event(logic [FLAG_BITS-1:0] f, logic v, logic [TOF_BITS-1:0] tf);
            event_rec_t want;
            if (due_events.size() == 0)
            begin
                report($sformatf("unexpected event flags=%0h valid=%0b tof=%0d",
                                 f, v, $signed(tf)));
                return;
            end
            want = due_events.pop_front();
            if (f !== want.flags)
                report($sformatf("event %0d flags: got %0h, want %0h", checked, f, want.flags));
            if (v !== want.valid)
                report($sformatf("event %0d valid: got %0b, want %0b", checked, v, want.valid));
            if (tf !== want.tof)
                report($sformatf("event %0d tof: got %0d, want %0d", checked,
                                 $signed(tf), $signed(want.tof)));
            checked++;
        endtask
    endclass

endpackage

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import cweb_pkg::*;
    import cweb_tb_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX      = '1;
    localparam logic [TYPE_BITS-1:0] IGNORED_LO    = 3'd3;
    localparam logic [TYPE_BITS-1:0] IGNORED_HI    = 3'd7;
    localparam logic [WINDOW_BITS-1:0] WINDOW_MAX  = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [WINDOW_BITS-1:0] cfg_wdata = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic                   cmd       = CMD_HIT;
    logic                   hit_valid = 1'b0;
    logic [TYPE_BITS-1:0]   hit_type  = '0;
    logic [TIME_BITS-1:0]   hit_time  = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [FLAG_BITS-1:0]   event_flags;
    logic                   event_valid;
    logic signed [TOF_BITS-1:0] event_tof;

    coincidence_tracker tracker;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    always #6 clk = ~clk;

    coincidence_window_event_builder_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .hit_valid   (hit_valid),
        .hit_type    (hit_type),
        .hit_time    (hit_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_flags (event_flags),
        .event_valid (event_valid),
        .event_tof   (event_tof)
    );

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.accept_item(cmd, hit_valid, hit_type, hit_time);
        if (rst_n && out_valid && !out_stall)
            tracker.check_event(event_flags, event_valid, event_tof);
    end

    // receiver back-pressure: free, coin-flip, mostly stalled, or a regular square wave
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 5) != 0);
            default: out_stall <= stall_left[2];
        endcase
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return TIME_BITS'(r[15:0]);
            1:       return TIME_MAX - TIME_BITS'(r[15:0]);
            default: return r[TIME_BITS-1:0];
        endcase
    endfunction

    task automatic send_item(logic c, logic hv, logic [TYPE_BITS-1:0] ty,
                             logic [TIME_BITS-1:0] t);
        in_valid  <= 1'b1;
        cmd       <= c;
        hit_valid <= hv;
        hit_type  <= ty;
        hit_time  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 30);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    // hold off until every event has left, then give the pipeline time to empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_events.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic load_window(logic [WINDOW_BITS-1:0] w);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_window(w);
    endtask

    // clusters of hits around a moving base time, with flushes and skipped hits mixed in
    task automatic random_phase(logic [WINDOW_BITS-1:0] w, int count);
        logic [TIME_BITS-1:0] base;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] offs;
        logic [TYPE_BITS-1:0] ty;
        int                   pick;
        int                   done;
        done = 0;
        base = rand_time();
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            ty   = ($urandom_range(0, 4) == 0) ? TYPE_BITS'($urandom_range(3, 7))
                                               : TYPE_BITS'($urandom_range(0, 2));
            if (pick < 6)
            begin
                send_item(CMD_FLUSH, 1'($urandom), TYPE_BITS'($urandom), rand_time());
                done++;
            end
            else if (pick < 12)
            begin
                send_item(CMD_HIT, 1'b0, ty, rand_time());
            end
            else
            begin
                if (pick < 30)
                begin
                    base = rand_time();
                    offs = '0;
                end
                else if (pick < 38)
                    offs = TIME_BITS'(w);
                else if (pick < 44)
                    offs = (w == '0) ? '0 : TIME_BITS'(w - 1);
                else
                    offs = (w == '0) ? '0 : TIME_BITS'($urandom_range(0, w - 1));
                t = $urandom_range(0, 1) ? base + offs : base - offs;
                send_item(CMD_HIT, 1'b1, ty, t);
                done++;
            end
        end
    endtask

    initial
    begin
        logic [WINDOW_BITS-1:0] windows[6];
        tracker = new();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start/stop pairing, repeated type, window edge, skipped hit, flushes
        send_item(CMD_HIT,   1'b1, TYPE_START, TIME_BITS'(100));
        send_item(CMD_HIT,   1'b1, TYPE_STOP,  TIME_BITS'(1099));
        send_item(CMD_HIT,   1'b1, TYPE_STOP,  TIME_BITS'(500));
        send_item(CMD_HIT,   1'b1, TYPE_AUX,   TIME_BITS'(1100));
        send_item(CMD_HIT,   1'b0, TYPE_START, '0);
        send_item(CMD_FLUSH, 1'b1, TYPE_STOP,  TIME_MAX);
        send_item(CMD_FLUSH, 1'b0, IGNORED_HI, '0);
        // ignored types alone, inside and outside the window
        send_item(CMD_HIT,   1'b1, IGNORED_HI, TIME_MAX);
        send_item(CMD_HIT,   1'b1, IGNORED_LO, '0);
        send_item(CMD_HIT,   1'b1, TYPE_STOP,  TIME_MAX);
        send_item(CMD_HIT,   1'b1, IGNORED_LO, TIME_MAX - 10);
        send_item(CMD_HIT,   1'b1, IGNORED_HI, '0);
        send_item(CMD_HIT,   1'b1, TYPE_START, TIME_MAX);
        send_item(CMD_FLUSH, 1'b0, TYPE_START, '0);
        send_item(CMD_HIT,   1'b1, TYPE_START, TIME_BITS'(5));
        send_item(CMD_HIT,   1'b1, TYPE_STOP,  '0);
        send_item(CMD_FLUSH, 1'b1, TYPE_AUX,   TIME_MAX);

        // zero window: nothing ever coincides
        load_window('0);
        send_item(CMD_HIT,   1'b1, TYPE_START, TIME_BITS'(10));
        send_item(CMD_HIT,   1'b1, TYPE_START, TIME_BITS'(10));
        send_item(CMD_FLUSH, 1'b0, TYPE_AUX,   '0);

        load_window(WINDOW_MAX);
        send_item(CMD_HIT,   1'b1, TYPE_STOP,  '0);
        send_item(CMD_HIT,   1'b1, TYPE_START, TIME_BITS'(WINDOW_MAX - 1));
        send_item(CMD_HIT,   1'b1, TYPE_AUX,   TIME_BITS'(WINDOW_MAX));
        send_item(CMD_FLUSH, 1'b1, IGNORED_LO, TIME_MAX);

        windows[0] = WINDOW_RESET;
        windows[1] = '0;
        windows[2] = WINDOW_BITS'(1);
        windows[3] = WINDOW_MAX;
        windows[4] = WINDOW_BITS'($urandom_range(2, 5000));
        windows[5] = WINDOW_BITS'($urandom);
        foreach (windows[i])
        begin
            load_window(windows[i]);
            random_phase(windows[i], 50);
            settle();
            random_phase(windows[i], 50);
        end

        settle();
        repeat (8)
            @(posedge clk);
        if (tracker.mismatches == 0 && tracker.due_events.size() == 0)
            $display("coincidence_window_event_builder_unit verification clean");
        else
            $display("coincidence_window_event_builder_unit verification failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("coincidence_window_event_builder_unit verification failed");
        $finish;
    end

endmodule
